/* design/rational_arithmetic_unit_defines.svh */
// Assertion macros shared by the rational arithmetic unit RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define RAU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) \
        else $error("assertion failed");
`else
`define RAU_ASSERT_IMPL(label, clk, rstn, prop)
`define RAU_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

/* design/rau_pkg.sv */
// Shared types and codes for the rational arithmetic unit.
// Depends on nothing.
`timescale 1ns / 1ps
package rau_pkg;
    localparam int WIDTH_DEFAULT = 32;
    localparam int MAG_W = 64;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    localparam logic [1:0] CMP_EQ = 2'b00;
    localparam logic [1:0] CMP_GT = 2'b01;
    localparam logic [1:0] CMP_LT = 2'b11;

    // Datapath steps requested by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_A,
        OP_MUL_B,
        OP_MUL_D,
        OP_MUL_N,
        OP_COMBINE,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_den;
        logic num_zero;
        logic gcd_done;
        logic div_done;
    } dp_stat_t;
endpackage

/* design/rau_ctrl.sv */
// Controller sequencing one item through the rational datapath.
// Depends on rau_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_defines.svh"
module rau_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output rau_pkg::dp_cmd_t  cmd,
    input  rau_pkg::dp_stat_t stat
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MA, S_MB, S_MD, S_MN, S_COMB, S_GINIT, S_GCD,
        S_DINIT, S_DIV, S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    // Idle, and output register free or draining this cycle: take the next item.
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE:  cmd.op = (s_valid && s_ready) ? OP_LOAD : OP_NONE;
            S_MA:    cmd.op = OP_MUL_A;
            S_MB:    cmd.op = OP_MUL_B;
            S_MD:    cmd.op = OP_MUL_D;
            S_MN:    cmd.op = OP_MUL_N;
            S_COMB:  cmd.op = OP_COMBINE;
            S_GINIT: cmd.op = OP_GCD_INIT;
            S_GCD:   cmd.op = OP_GCD_STEP;
            S_DINIT: cmd.op = OP_DIV_INIT;
            S_DIV:   cmd.op = OP_DIV_STEP;
            S_FIN:   cmd.op = OP_FINISH;
            S_OUT:   cmd.op = OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // Raise valid when the result is handed over, drop it once taken.
            if (state_reg == S_OUT && (!m_valid_reg || m_ready)) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:  if (s_valid && s_ready) state_reg <= S_MA;
                S_MA:    state_reg <= S_MB;
                S_MB:    state_reg <= S_MD;
                S_MD:    state_reg <= S_MN;
                S_MN:    state_reg <= S_COMB;
                S_COMB:  state_reg <= S_GINIT;
                S_GINIT: state_reg <= (stat.zero_den || stat.num_zero) ? S_FIN : S_GCD;
                S_GCD:   if (stat.gcd_done) state_reg <= S_DINIT;
                S_DINIT: state_reg <= S_DIV;
                S_DIV:   if (stat.div_done) state_reg <= S_FIN;
                S_FIN:   state_reg <= S_OUT;
                S_OUT:   if (!m_valid_reg || m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `RAU_ASSERT_IMPL(a_ready_idle, aclk, aresetn, s_ready |-> state_reg == S_IDLE)
    `RAU_ASSERT_NEXT(a_load_starts, aclk, aresetn, s_valid && s_ready, state_reg == S_MA)
    `RAU_ASSERT_NEXT(a_out_sets_valid, aclk, aresetn, state_reg == S_OUT && (!m_valid_reg || m_ready), m_valid_reg)
endmodule

/* design/rau_datapath.sv */
// Datapath: operand capture, products, binary GCD and two side-by-side dividers.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_datapath #(
    parameter int WIDTH = rau_pkg::WIDTH_DEFAULT
) (
    input  logic               aclk,
    input  rau_pkg::dp_cmd_t   cmd,
    output rau_pkg::dp_stat_t  stat,
    input  logic [1:0]         s_func,
    input  logic signed [31:0] s_x_num,
    input  logic signed [31:0] s_x_den,
    input  logic signed [31:0] s_y_num,
    input  logic signed [31:0] s_y_den,
    output logic signed [31:0] m_res_num,
    output logic [30:0]        m_res_den,
    output logic signed [1:0]  m_cmp,
    output logic [1:0]         m_status
);
    import rau_pkg::*;

    localparam int CW = $clog2(MAG_W + 1);

    logic [1:0]       func_reg;
    logic [31:0]      xn_reg, xd_reg, yn_reg, yd_reg;
    logic             xnn_reg, xdn_reg, ynn_reg, ydn_reg;
    logic [MAG_W-1:0] a_reg, b_reg, den_reg, nm_reg, prod;
    logic             nneg_reg, zden_reg;
    logic [1:0]       cmp_reg;
    logic [MAG_W-1:0] ga_reg, gb_reg, g_reg;
    logic [CW-1:0]    sh_reg, cnt_reg;
    // Two restoring dividers run side by side: num/g and den/g.
    logic [MAG_W-1:0] q0_reg, r0_reg, q1_reg, r1_reg;
    logic [31:0]      rnum_reg;
    logic [30:0]      rden_reg;
    logic [1:0]       st_reg;

    function automatic logic [32:0] take(input logic [31:0] raw);
        logic [WIDTH-1:0] v;
        logic [32:0] r;
        v = raw[WIDTH-1:0];
        r[32] = v[WIDTH-1];
        r[31:0] = v[WIDTH-1] ? 32'(-{1'b1, v}) & 32'((64'd1 << WIDTH) - 1)
                             : 32'(v);
        // most negative value: magnitude 2^(WIDTH-1)
        if (v[WIDTH-1]) r[31:0] = 32'((64'd1 << WIDTH) - 64'(v));
        return r;
    endfunction

    logic [32:0] txn, txd, tyn, tyd;
    assign txn = take(s_x_num);
    assign txd = take(s_x_den);
    assign tyn = take(s_y_num);
    assign tyd = take(s_y_den);

    logic xs, ys, an, bn;
    assign xs = xnn_reg ^ xdn_reg;
    assign ys = ynn_reg ^ ydn_reg;
    assign an = xs && xn_reg != 0;
    assign bn = ys && yn_reg != 0;

    logic [31:0] mul_a, mul_b;
    always_comb begin
        unique case (cmd.op)
            OP_MUL_A: begin mul_a = xn_reg; mul_b = yd_reg; end
            OP_MUL_B: begin mul_a = yn_reg; mul_b = xd_reg; end
            OP_MUL_D: begin
                mul_a = xd_reg;
                mul_b = (func_reg == FUNC_DIV) ? yn_reg : yd_reg;
            end
            default:  begin mul_a = xn_reg; mul_b = yn_reg; end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    // Signed-magnitude sum of a and (b with sign bng).
    function automatic logic [MAG_W:0] smadd(input logic [MAG_W-1:0] am, input logic ang,
                                             input logic [MAG_W-1:0] bm, input logic bng);
        logic [MAG_W:0] r;
        if (ang == bng) r = {ang, am + bm};
        else if (am >= bm) r = {ang, am - bm};
        else r = {bng, bm - am};
        if (r[MAG_W-1:0] == 0) r[MAG_W] = 1'b0;
        return r;
    endfunction

    logic [MAG_W:0] diff_s;
    assign diff_s = smadd(a_reg, an, b_reg, !bn && b_reg != 0);

    logic [MAG_W-1:0] gmin, gmax, gdiff, s0n, s1n;
    assign gmin  = (ga_reg < gb_reg) ? ga_reg : gb_reg;
    assign gmax  = (ga_reg < gb_reg) ? gb_reg : ga_reg;
    assign gdiff = gmax - gmin;
    assign s0n = {r0_reg[MAG_W-2:0], q0_reg[MAG_W-1]};
    assign s1n = {r1_reg[MAG_W-2:0], q1_reg[MAG_W-1]};

    logic [MAG_W-1:0] half;
    assign half = 64'd1 << (WIDTH - 1);

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                func_reg <= s_func;
                {xnn_reg, xn_reg} <= txn;
                {xdn_reg, xd_reg} <= txd;
                {ynn_reg, yn_reg} <= tyn;
                {ydn_reg, yd_reg} <= tyd;
            end
            OP_MUL_A: a_reg <= prod;
            OP_MUL_B: b_reg <= prod;
            OP_MUL_D: den_reg <= prod;
            OP_MUL_N: nm_reg <= prod;
            OP_COMBINE: begin
                zden_reg <= (xd_reg == 0) || (yd_reg == 0);
                cmp_reg  <= (diff_s[MAG_W-1:0] == 0) ? CMP_EQ
                          : (diff_s[MAG_W] ? CMP_LT : CMP_GT);
                unique case (func_reg)
                    FUNC_ADD: {nneg_reg, nm_reg} <= smadd(a_reg, an, b_reg, bn);
                    FUNC_SUB: {nneg_reg, nm_reg} <= diff_s;
                    FUNC_MUL: nneg_reg <= (xs != ys) && nm_reg != 0;
                    default: begin
                        nm_reg   <= a_reg;
                        nneg_reg <= (xs != ys) && a_reg != 0;
                    end
                endcase
            end
            OP_GCD_INIT: begin
                ga_reg <= nm_reg;
                gb_reg <= den_reg;
                sh_reg <= '0;
            end
            OP_GCD_STEP: begin
                // Stein: strip common twos, then subtract the smaller.
                if (gb_reg == 0 || ga_reg == 0) begin
                    g_reg <= (ga_reg | gb_reg) << sh_reg;
                end else if (!ga_reg[0] && !gb_reg[0]) begin
                    ga_reg <= ga_reg >> 1;
                    gb_reg <= gb_reg >> 1;
                    sh_reg <= sh_reg + 1'b1;
                end else if (!ga_reg[0]) ga_reg <= ga_reg >> 1;
                else if (!gb_reg[0]) gb_reg <= gb_reg >> 1;
                else begin
                    ga_reg <= gmin;
                    gb_reg <= gdiff;
                end
            end
            OP_DIV_INIT: begin
                q0_reg <= nm_reg;
                q1_reg <= den_reg;
                r0_reg <= '0;
                r1_reg <= '0;
                cnt_reg <= '0;
            end
            OP_DIV_STEP: begin
                cnt_reg <= cnt_reg + 1'b1;
                if ({r0_reg[MAG_W-1], s0n} >= {1'b0, g_reg}) begin
                    r0_reg <= s0n - g_reg;
                    q0_reg <= {q0_reg[MAG_W-2:0], 1'b1};
                end else begin
                    r0_reg <= s0n;
                    q0_reg <= {q0_reg[MAG_W-2:0], 1'b0};
                end
                if ({r1_reg[MAG_W-1], s1n} >= {1'b0, g_reg}) begin
                    r1_reg <= s1n - g_reg;
                    q1_reg <= {q1_reg[MAG_W-2:0], 1'b1};
                end else begin
                    r1_reg <= s1n;
                    q1_reg <= {q1_reg[MAG_W-2:0], 1'b0};
                end
            end
            OP_FINISH: begin
                rnum_reg <= '0;
                rden_reg <= 31'd1;
                if (zden_reg) begin
                    st_reg  <= ST_ZERO_DEN;
                    cmp_reg <= CMP_EQ;
                end else if (den_reg == 0) st_reg <= ST_ZERO_DEN;
                else if (nm_reg == 0) st_reg <= ST_OK;
                else if (q1_reg > half - 1 || (nneg_reg ? q0_reg > half : q0_reg > half - 1))
                    st_reg <= ST_OVERFLOW;
                else begin
                    st_reg <= ST_OK;
                    rnum_reg <= nneg_reg ? 32'(-q0_reg) : q0_reg[31:0];
                    rden_reg <= q1_reg[30:0];
                end
            end
            default: ;
        endcase
    end

    assign stat.zero_den = (xd_reg == 0) || (yd_reg == 0) || (den_reg == 0);
    assign stat.num_zero = (nm_reg == 0);
    assign stat.gcd_done = (ga_reg == 0) || (gb_reg == 0);
    assign stat.div_done = (cnt_reg == CW'(MAG_W - 1));

    assign m_res_num = rnum_reg;
    assign m_res_den = rden_reg;
    assign m_cmp     = cmp_reg;
    assign m_status  = st_reg;
endmodule

/* design/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl and rau_datapath.
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | func, x_num, x_den, y_num, y_den
//  m_      | out       | m_valid / m_ready  | res_num, res_den, cmp, status
// One item at a time: load and products, then binary GCD on the 64-bit numerator
// and denominator, then the two bit-serial dividers, then finish and output.
// Zero denominators and zero numerators skip the GCD and division.
// Reset (aresetn low at a clock edge) drops any item at work.
// A stalled result holds in the output register; the next item waits for it.
`timescale 1ns / 1ps
module rational_arithmetic_unit #(
    parameter int WIDTH = rau_pkg::WIDTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic signed [31:0] s_x_num,
    input  logic signed [31:0] s_x_den,
    input  logic signed [31:0] s_y_num,
    input  logic signed [31:0] s_y_den,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_res_num,
    output logic [30:0]        m_res_den,
    output logic signed [1:0]  m_cmp,
    output logic [1:0]         m_status
);
    import rau_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence each item through products, reduction and output.
    rau_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .stat(stat)
    );

    rau_datapath #(.WIDTH(WIDTH)) u_dp (
        .aclk(aclk), .cmd(cmd), .stat(stat),
        .s_func(s_func), .s_x_num(s_x_num), .s_x_den(s_x_den),
        .s_y_num(s_y_num), .s_y_den(s_y_den),
        .m_res_num(m_res_num), .m_res_den(m_res_den),
        .m_cmp(m_cmp), .m_status(m_status)
    );
endmodule

/* verif/tb_rational_arithmetic_unit.sv */
// Self-checking testbench for the rational arithmetic unit: directed and random fractions,
// predicted results compared field by field against the block's output items.
// Depends on rau_pkg and rational_arithmetic_unit.
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    typedef struct packed {
        func_t       func;
        logic [31:0] x_num;
        logic [31:0] x_den;
        logic [31:0] y_num;
        logic [31:0] y_den;
    } operands_t;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic [1:0]  cmp;
        status_t     status;
    } fraction_res_t;

    localparam int HOLD_CYCLES = 1500;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = '0;
    logic [31:0] s_x_num = '0;
    logic [31:0] s_x_den = '0;
    logic [31:0] s_y_num = '0;
    logic [31:0] s_y_den = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_res_num;
    logic [30:0] m_res_den;
    logic [1:0]  m_cmp;
    logic [1:0]  m_status;

    operands_t     pending_items[$];
    fraction_res_t expected_fractions[$];
    int            mismatches = 0;
    bit            quiet_phase = 1'b0;  // no idling in the last part of the run
    bit            sender_hold = 1'b0;  // pause the sender until all results are in
    bit            hold_request = 1'b0; // start the long receiver stall
    int            hold_count = 0;      // long receiver stall, counted in cycles
    bit            in_taken = 1'b0;     // item accepted at the last rising edge
    int            send_gap = 0;
    int            recv_gap = 0;

    rational_arithmetic_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_x_num(s_x_num), .s_x_den(s_x_den), .s_y_num(s_y_num), .s_y_den(s_y_den),
        .m_valid(m_valid), .m_ready(m_ready), .m_res_num(m_res_num),
        .m_res_den(m_res_den), .m_cmp(m_cmp), .m_status(m_status)
    );

    always #1 aclk = ~aclk;

    // Magnitude of a signed 32-bit operand, widened to 64 bits.
    function automatic logic [63:0] magnitude(input logic [31:0] v);
        return v[31] ? 64'd0 - {{32{1'b1}}, v} : {32'd0, v};
    endfunction

    // Signed sum of two sign/magnitude values; a zero sum is positive.
    function automatic void signed_sum(input bit an, input logic [63:0] am,
                                       input bit bn, input logic [63:0] bm,
                                       output bit rn, output logic [63:0] rm);
        if (an == bn) begin
            rn = an; rm = am + bm;
        end else if (am >= bm) begin
            rn = an; rm = am - bm;
        end else begin
            rn = bn; rm = bm - am;
        end
        if (rm == 0) rn = 1'b0;
    endfunction

    function automatic fraction_res_t predict_fraction(input operands_t it);
        fraction_res_t r;
        logic [63:0] xn, xd, yn, yd, am, bm, nm, den, g, a, b, t, qn, qd;
        bit xs, ys, an, bn, nn;
        r = '{num: 32'd0, den: 31'd1, cmp: CMP_EQ, status: ST_OK};
        xn = magnitude(it.x_num); xd = magnitude(it.x_den);
        yn = magnitude(it.y_num); yd = magnitude(it.y_den);
        if (xd == 0 || yd == 0) begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        xs = it.x_num[31] != it.x_den[31];
        ys = it.y_num[31] != it.y_den[31];
        an = xs && xn != 0; am = xn * yd;
        bn = ys && yn != 0; bm = yn * xd;
        signed_sum(an, am, (bm != 0) ? !bn : bn, bm, nn, nm);
        r.cmp = (nm == 0) ? CMP_EQ : (nn ? CMP_LT : CMP_GT);
        den = xd * yd;
        case (it.func)
            FUNC_ADD: signed_sum(an, am, bn, bm, nn, nm);
            FUNC_SUB: ;
            FUNC_MUL: begin
                nm = xn * yn; nn = (xs != ys) && nm != 0;
            end
            default: begin
                nm = am; nn = (xs != ys) && nm != 0; den = xd * yn;
            end
        endcase
        if (den == 0) begin
            r.status = ST_ZERO_DEN;
        end else if (nm != 0) begin
            a = nm; b = den;
            while (b != 0) begin
                t = a % b; a = b; b = t;
            end
            g = a;
            qn = nm / g; qd = den / g;
            if (qd > 64'h7FFF_FFFF || qn > (nn ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
                r.status = ST_OVERFLOW;
            end else begin
                r.num = nn ? 32'd0 - qn[31:0] : qn[31:0];
                r.den = qd[30:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
            4, 5: return $urandom_range(0, 40) - 20;
            6: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic operands_t make_item(input logic [1:0] f, input logic [31:0] a,
                                            input logic [31:0] b, input logic [31:0] c,
                                            input logic [31:0] d);
        operands_t it;
        it.func = func_t'(f);
        it.x_num = a; it.x_den = b; it.y_num = c; it.y_den = d;
        return it;
    endfunction

    // Driver: offer the next pending item at the falling edge, hold until accepted.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                // item taken at the last rising edge
                void'(pending_items.pop_front());
            end
            if (!s_valid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (sender_hold || pending_items.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(1, 14);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_func  <= pending_items[0].func;
                    s_x_num <= pending_items[0].x_num;
                    s_x_den <= pending_items[0].x_den;
                    s_y_num <= pending_items[0].y_num;
                    s_y_den <= pending_items[0].y_den;
                end
            end
        end
    end

    // Receiver: long hold-off once requested, otherwise random stall bursts.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_request && hold_count < HOLD_CYCLES) begin
                hold_count <= hold_count + 1;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                recv_gap <= $urandom_range(1, 14);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: record accepted inputs and check accepted results at the rising edge.
    always @(posedge aclk) begin
        fraction_res_t want;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_fractions.push_back(predict_fraction(pending_items[0]));
            if (m_valid && m_ready) begin
                if (expected_fractions.size() == 0) begin
                    report_mismatch("unexpected result", m_res_num, 32'd0);
                end else begin
                    want = expected_fractions.pop_front();
                    if (m_res_num !== want.num) report_mismatch("res_num", m_res_num, want.num);
                    if (m_res_den !== want.den)
                        report_mismatch("res_den", {1'b0, m_res_den}, {1'b0, want.den});
                    if (m_cmp !== want.cmp)
                        report_mismatch("cmp", 32'(m_cmp), 32'(want.cmp));
                    if (m_status !== want.status)
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                end
            end
        end
    end

    initial begin
        operands_t it;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, every operation, zero denominators, divide by zero,
        // zero numerators, negative denominators and overflow.
        for (int f = 0; f < 4; f++) begin
            pending_items.push_back(make_item(2'(f), 32'd1, 32'd2, 32'd1, 32'd3));
            pending_items.push_back(make_item(2'(f), 32'h8000_0000, 32'd1,
                                              32'h7FFF_FFFF, 32'd1));
            pending_items.push_back(make_item(2'(f), -32'sd3, -32'sd6, 32'd4, -32'sd8));
            pending_items.push_back(make_item(2'(f), 32'h7FFF_FFFF, 32'h8000_0000,
                                              32'h8000_0000, 32'h7FFF_FFFF));
        end
        pending_items.push_back(make_item(FUNC_ADD, 32'd5, 32'd0, 32'd1, 32'd1));
        pending_items.push_back(make_item(FUNC_MUL, 32'd5, 32'd1, 32'd1, 32'd0));
        pending_items.push_back(make_item(FUNC_DIV, 32'd5, 32'd7, 32'd0, -32'sd3));
        pending_items.push_back(make_item(FUNC_SUB, 32'd0, 32'd9, 32'd0, -32'sd4));
        pending_items.push_back(make_item(FUNC_MUL, 32'd0, -32'sd9, 32'd7, 32'd4));
        pending_items.push_back(make_item(FUNC_DIV, 32'h8000_0000, 32'd1, -32'sd1, 32'd1));
        pending_items.push_back(make_item(FUNC_SUB, 32'd3, 32'd4, 32'd6, 32'd8));
        pending_items.push_back(make_item(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        wait (pending_items.size() == 0);

        // Long receiver hold-off while the sender keeps offering items.
        for (int i = 0; i < 20; i++)
            pending_items.push_back(make_item(2'($urandom_range(0, 3)), pick_value(),
                                              pick_value(), pick_value(), pick_value()));
        @(negedge aclk);
        hold_request <= 1'b1;
        wait (pending_items.size() == 0);

        // Random part; pause the sender once until the block has drained.
        for (int i = 0; i < 960; i++) begin
            if (i == 300) begin
                wait (pending_items.size() == 0);
                @(negedge aclk);
                sender_hold <= 1'b1;
                wait (expected_fractions.size() == 0);
                @(negedge aclk);
                sender_hold <= 1'b0;
            end
            if (i == 850) begin
                wait (pending_items.size() == 0);
                quiet_phase = 1'b1;
            end
            pending_items.push_back(make_item(2'($urandom_range(0, 3)), pick_value(),
                                              pick_value(), pick_value(), pick_value()));
        end
        wait (pending_items.size() == 0);
        wait (expected_fractions.size() == 0);
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && expected_fractions.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Timeout: 1000 items plus worst stalls, several times over.
    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
